### rtl/core/itoa_pkg.sv
// Shared types and character constants for the integer-to-decimal-text block.
`timescale 1ns / 1ps
`default_nettype none

package itoa_pkg;

   localparam int DIGIT_BITS = 4;

   typedef logic [7:0]            char_type;
   typedef logic [DIGIT_BITS-1:0] digit_type;

   localparam char_type  CHAR_ZERO  = 8'd48;
   localparam char_type  CHAR_MINUS = 8'd45;
   localparam digit_type DIGIT_NINE = 4'd9;

   // A BCD digit at or above this limit gets the correction added before the shift.
   localparam digit_type DABBLE_LIMIT = 4'd5;
   localparam digit_type DABBLE_ADD   = 4'd3;

endpackage

`default_nettype wire

### rtl/core/int_to_decimal_text.sv
// Top level of the integer-to-decimal-text block: sequencer, conversion registers and output word.
//
// Each accepted word on req_value is a signed two's-complement integer; the block returns its
// decimal text on rsp_text_char, one character per word, a leading minus sign for negative
// values, most significant digit first, and rsp_last high on the final character. The most
// negative value prints in full and zero prints as a single '0'. One item is handled at a
// time and req_ready is low while it is in progress. The magnitude is converted to BCD by a
// shift-and-add-3 unit at one bit per cycle, leading zero digits are then dropped at one per
// cycle, and characters leave at one per cycle while the output is taken.
`timescale 1ns / 1ps
`default_nettype none

module int_to_decimal_text
   import itoa_pkg::*;
#(
   parameter int VALUE_BITS = 32
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         req_valid,
   output logic                              req_ready,
   input  wire logic signed [VALUE_BITS-1:0] req_value,
   output logic                              rsp_valid,
   input  wire logic                         rsp_ready,
   output logic             [7:0]            rsp_text_char,
   output logic                              rsp_last
);

   localparam int NDIG  = ((VALUE_BITS - 1) * 30103) / 100000 + 1;
   localparam int BCD_W = NDIG * DIGIT_BITS;
   localparam int CNT_W = $clog2(VALUE_BITS);
   localparam int DIG_W = $clog2(NDIG);

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_CONV = 3'd1;
   localparam logic [2:0] ST_SKIP = 3'd2;
   localparam logic [2:0] ST_SIGN = 3'd3;
   localparam logic [2:0] ST_EMIT = 3'd4;

   logic [2:0]            state_ff, state_in;
   logic [VALUE_BITS-1:0] bin_ff, bin_in;
   logic [BCD_W-1:0]      bcd_ff, bcd_in;
   logic [CNT_W-1:0]      cnt_ff, cnt_in;
   logic [DIG_W-1:0]      dig_ff, dig_in;
   logic                  neg_ff, neg_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   char_type              char_ff, char_in;
   logic                  last_ff, last_in;

   logic [BCD_W-1:0]      bcd_step;
   digit_type             top_digit;
   logic                  slot_free;
   logic                  req_fire;

   itoa_dabble #(
      .NDIG (NDIG)
   ) u_dabble (
      .bcd_in  (bcd_ff),
      .bit_in  (bin_ff[VALUE_BITS-1]),
      .bcd_out (bcd_step)
   );

   assign top_digit = bcd_ff[BCD_W-1 -: DIGIT_BITS];
   assign slot_free = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == ST_IDLE);
   assign req_fire  = req_valid && req_ready;

   always_comb begin
      state_in     = state_ff;
      bin_in       = bin_ff;
      bcd_in       = bcd_ff;
      cnt_in       = cnt_ff;
      dig_in       = dig_ff;
      neg_in       = neg_ff;
      char_in      = char_ff;
      last_in      = last_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               neg_in   = req_value[VALUE_BITS-1];
               bin_in   = req_value[VALUE_BITS-1] ? (~req_value + 1'b1) : req_value;
               bcd_in   = '0;
               cnt_in   = CNT_W'(VALUE_BITS - 1);
               state_in = ST_CONV;
            end
         end
         ST_CONV: begin
            bcd_in = bcd_step;
            bin_in = {bin_ff[VALUE_BITS-2:0], 1'b0};
            cnt_in = cnt_ff - 1'b1;
            if (cnt_ff == '0) begin
               dig_in   = DIG_W'(NDIG - 1);
               state_in = ST_SKIP;
            end
         end
         ST_SKIP: begin
            if (top_digit == '0 && dig_ff != '0) begin
               bcd_in = {bcd_ff[BCD_W-DIGIT_BITS-1:0], {DIGIT_BITS{1'b0}}};
               dig_in = dig_ff - 1'b1;
            end else begin
               state_in = neg_ff ? ST_SIGN : ST_EMIT;
            end
         end
         ST_SIGN: begin
            if (slot_free) begin
               char_in      = CHAR_MINUS;
               last_in      = 1'b0;
               rsp_valid_in = 1'b1;
               state_in     = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (slot_free) begin
               char_in      = CHAR_ZERO + {{(8-DIGIT_BITS){1'b0}}, top_digit};
               last_in      = (dig_ff == '0);
               rsp_valid_in = 1'b1;
               bcd_in       = {bcd_ff[BCD_W-DIGIT_BITS-1:0], {DIGIT_BITS{1'b0}}};
               dig_in       = dig_ff - 1'b1;
               if (dig_ff == '0) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      bin_ff  <= bin_in;
      bcd_ff  <= bcd_in;
      cnt_ff  <= cnt_in;
      dig_ff  <= dig_in;
      neg_ff  <= neg_in;
      char_ff <= char_in;
      last_ff <= last_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_text_char = char_ff;
   assign rsp_last      = last_ff;

   // An accepted word starts the conversion and holds off the next one.
   a_accept_starts: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> state_ff == ST_CONV && !req_ready)
      else $error("accepted word did not start conversion");

   // Every output word is a minus sign that is never last, or a decimal digit.
   a_char_legal: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_text_char == CHAR_MINUS && !rsp_last) ||
                    (rsp_text_char >= CHAR_ZERO &&
                     rsp_text_char <= CHAR_ZERO + {4'd0, DIGIT_NINE}))
      else $error("output word is not a legal character");

   // The sign is only sent for a negative value.
   a_sign_negative: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_SIGN |-> neg_ff)
      else $error("minus sign for a non-negative value");

   // Digits reaching the output are already valid BCD.
   a_digit_bcd: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_EMIT |-> top_digit <= DIGIT_NINE)
      else $error("emitted digit is not valid BCD");

endmodule

`default_nettype wire

### rtl/core/itoa_dabble.sv
// Shift-and-add-3 unit that moves one binary bit into a packed BCD register.
`timescale 1ns / 1ps
`default_nettype none

module itoa_dabble
   import itoa_pkg::*;
#(
   parameter int NDIG = 10
) (
   input  wire logic [NDIG*DIGIT_BITS-1:0] bcd_in,
   input  wire logic                       bit_in,
   output logic      [NDIG*DIGIT_BITS-1:0] bcd_out
);

   logic [NDIG*DIGIT_BITS-1:0] adj;

   always_comb begin
      for (int i = 0; i < NDIG; i++) begin
         if (bcd_in[i*DIGIT_BITS +: DIGIT_BITS] >= DABBLE_LIMIT) begin
            adj[i*DIGIT_BITS +: DIGIT_BITS] = bcd_in[i*DIGIT_BITS +: DIGIT_BITS] + DABBLE_ADD;
         end else begin
            adj[i*DIGIT_BITS +: DIGIT_BITS] = bcd_in[i*DIGIT_BITS +: DIGIT_BITS];
         end
      end
   end

   assign bcd_out = {adj[NDIG*DIGIT_BITS-2:0], bit_in};

endmodule

`default_nettype wire
